FILE: design/bsfc_pkg.sv
// shared constants, types and rounding function for the binaural fir convolver
`default_nettype none

package bsfc_pkg;

    localparam int TAPS        = 512;
    localparam int TAP_AW      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W       = $clog2(TAPS + 1);
    localparam int IDX_BITS    = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + CNT_W;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TAP_L  = 2'd1;
    localparam logic [1:0] OP_TAP_R  = 2'd2;

    localparam logic signed [ACC_BITS:0] RND_HALF = (ACC_BITS + 1)'(1) << (COEF_BITS - 2);
    localparam logic signed [ACC_BITS:0] SAT_MAX  =
        (ACC_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS:0] SAT_MIN  = -SAT_MAX - (ACC_BITS + 1)'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              wr_hist;
        logic              wr_left;
        logic              wr_right;
        logic              wr_zero;
        logic [TAP_AW-1:0] wr_addr;
        logic              rd_en;
        logic [TAP_AW-1:0] hist_raddr;
        logic [TAP_AW-1:0] tap_raddr;
        logic              acc_clr;
        logic              mul_en;
        logic              acc_en;
        logic              load_out;
    } t_ctl;

    // round half up, then saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS:0] sum;
        logic signed [ACC_BITS:0] q;
        sum = (ACC_BITS + 1)'(acc) + RND_HALF;
        q   = sum >>> (COEF_BITS - 1);
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/binaural_stereo_fir_convolver_core.sv
// top level: sample and tap memories, two mac units, output register
// After reset the block sweeps its three 512-entry memories to zero, one entry
// a cycle, and holds o_stall high until the sweep ends. A tap-load transaction
// (opcode 1 or 2) gives no result; opcode 3 is dropped. For an audio sample
// the sequencer walks every tap once
// through one multiply-accumulate per channel, one memory read a cycle, then
// rounds and saturates into the output register. A finished result may wait
// there while the next transaction is accepted.
`default_nettype none

module binaural_stereo_fir_convolver_core (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic [bsfc_pkg::IDX_BITS-1:0]        i_tap_index,
    input  wire logic signed [bsfc_pkg::SAMPLE_BITS-1:0] i_sample_value,
    output logic                                      o_valid,
    input  wire                                       i_stall,
    output logic signed [bsfc_pkg::SAMPLE_BITS-1:0]   o_left_out,
    output logic signed [bsfc_pkg::SAMPLE_BITS-1:0]   o_right_out
);
    import bsfc_pkg::*;

    t_ctl                           ctl;
    logic                           ready;
    logic                           out_free;
    logic signed [SAMPLE_BITS-1:0]  wdata;

    logic signed [SAMPLE_BITS-1:0]  hist_mem  [TAPS];
    logic signed [COEF_BITS-1:0]    left_mem  [TAPS];
    logic signed [COEF_BITS-1:0]    right_mem [TAPS];

    logic signed [SAMPLE_BITS-1:0]  r_x;
    logic signed [COEF_BITS-1:0]    r_cl;
    logic signed [COEF_BITS-1:0]    r_cr;
    logic signed [SAMPLE_BITS-1:0]  mac_left;
    logic signed [SAMPLE_BITS-1:0]  mac_right;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_left;
    logic signed [SAMPLE_BITS-1:0]  r_right;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !ready;
    assign wdata    = ctl.wr_zero ? '0 : i_sample_value;

    bsfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_tap_index (i_tap_index),
        .i_out_free  (out_free),
        .o_ready     (ready),
        .o_ctl       (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.wr_hist) begin
            hist_mem[ctl.wr_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            r_x <= hist_mem[ctl.hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.wr_left) begin
            left_mem[ctl.wr_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            r_cl <= left_mem[ctl.tap_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.wr_right) begin
            right_mem[ctl.wr_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            r_cr <= right_mem[ctl.tap_raddr];
        end
    end

    bsfc_mac u_mac_left (
        .i_clk     (i_clk),
        .i_acc_clr (ctl.acc_clr),
        .i_mul_en  (ctl.mul_en),
        .i_acc_en  (ctl.acc_en),
        .i_x       (r_x),
        .i_c       (r_cl),
        .o_result  (mac_left)
    );

    bsfc_mac u_mac_right (
        .i_clk     (i_clk),
        .i_acc_clr (ctl.acc_clr),
        .i_mul_en  (ctl.mul_en),
        .i_acc_en  (ctl.acc_en),
        .i_x       (r_x),
        .i_c       (r_cr),
        .o_result  (mac_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_left  <= mac_left;
            r_right <= mac_right;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

    // no transaction is taken while the tap walk reads the memories
    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rd_en |-> !(i_valid && !o_stall))
        else $error("transaction accepted during tap walk");

    // accumulation follows a multiply in the previous cycle
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.acc_en |-> $past(ctl.mul_en))
        else $error("accumulate without preceding multiply");

    // the mac pipeline is empty when a result is loaded
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_out |-> (!ctl.mul_en && !ctl.acc_en && !ctl.rd_en))
        else $error("result loaded before mac pipeline drained");

endmodule

`default_nettype wire

FILE: design/bsfc_mac.sv
// shared multiply-accumulate unit for one output channel
`default_nettype none

module bsfc_mac (
    input  wire                                      i_clk,
    input  wire                                      i_acc_clr,
    input  wire                                      i_mul_en,
    input  wire                                      i_acc_en,
    input  wire logic signed [bsfc_pkg::SAMPLE_BITS-1:0] i_x,
    input  wire logic signed [bsfc_pkg::COEF_BITS-1:0]   i_c,
    output logic signed [bsfc_pkg::SAMPLE_BITS-1:0]      o_result
);
    import bsfc_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_x * i_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_clr) begin
            r_acc <= '0;
        end else if (i_acc_en) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end
    end

    assign o_result = round_sat(r_acc);

endmodule

`default_nettype wire

FILE: design/bsfc_ctrl.sv
// sequencer: clearing sweep, tap loads and the per-sample tap walk
`default_nettype none

module bsfc_ctrl (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [bsfc_pkg::IDX_BITS-1:0] i_tap_index,
    input  wire                             i_out_free,
    output logic                            o_ready,
    output bsfc_pkg::t_ctl                  o_ctl
);
    import bsfc_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [TAP_AW-1:0]   r_ptr, n_ptr;
    logic                r_v1, r_v2;
    logic                accept;
    logic                k_last;
    logic                idx_ok;
    logic [TAP_AW:0]     wrap_addr;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign k_last = (r_k == CNT_W'(TAPS - 1));
    assign idx_ok = ({1'b0, i_tap_index} < (IDX_BITS + 1)'(TAPS));
    // history slot of tap k: ptr - k modulo the buffer depth
    assign wrap_addr = {1'b0, r_ptr} + (TAP_AW + 1)'(TAPS) - {1'b0, r_k[TAP_AW-1:0]};

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_ptr   = r_ptr;
        case (r_state)
            ST_CLEAR: begin
                n_k = r_k + CNT_W'(1);
                if (k_last) begin
                    n_state = ST_IDLE;
                    n_k     = '0;
                end
            end
            ST_IDLE: begin
                n_k = '0;
                if (accept && i_opcode == OP_SAMPLE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_k = r_k + CNT_W'(1);
                if (k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                    n_ptr   = (r_ptr == TAP_AW'(TAPS - 1)) ? '0 : r_ptr + TAP_AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_ctl            = '0;
        o_ctl.mul_en     = r_v1;
        o_ctl.acc_en     = r_v2;
        o_ctl.tap_raddr  = r_k[TAP_AW-1:0];
        o_ctl.hist_raddr = (r_k[TAP_AW-1:0] > r_ptr) ? wrap_addr[TAP_AW-1:0]
                                                     : r_ptr - r_k[TAP_AW-1:0];
        o_ctl.wr_addr    = r_ptr;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.wr_hist  = 1'b1;
                o_ctl.wr_left  = 1'b1;
                o_ctl.wr_right = 1'b1;
                o_ctl.wr_zero  = 1'b1;
                o_ctl.wr_addr  = r_k[TAP_AW-1:0];
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_SAMPLE) begin
                        o_ctl.wr_hist = 1'b1;
                        o_ctl.acc_clr = 1'b1;
                    end else begin
                        o_ctl.wr_addr  = i_tap_index[TAP_AW-1:0];
                        o_ctl.wr_left  = (i_opcode == OP_TAP_L) && idx_ok;
                        o_ctl.wr_right = (i_opcode == OP_TAP_R) && idx_ok;
                    end
                end
            end
            ST_RUN: begin
                o_ctl.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_ctl.load_out = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_ptr   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ptr   <= n_ptr;
            r_v1    <= (r_state == ST_RUN);
            r_v2    <= r_v1;
        end
    end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the binaural stereo fir convolver core
`timescale 1ns / 1ps

module testbench;
    import bsfc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 12_000_000;
    localparam int         RANDOM_ITEMS = 1170;
    localparam int         DRAIN_CYCLES = 600;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_stereo;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SHORT,
        STALL_LONG
    } t_stall_mode;

    logic                          i_clk;
    logic                          r_rst_n = 1'b0;
    logic                          r_valid = 1'b0;
    logic [1:0]                    r_opcode = OP_SAMPLE;
    logic [IDX_BITS-1:0]           r_tap_index = '0;
    logic signed [SAMPLE_BITS-1:0] r_sample_value = '0;
    logic                          r_stall = 1'b0;
    wire                           o_stall;
    wire                           o_valid;
    wire signed [SAMPLE_BITS-1:0]  o_left_out;
    wire signed [SAMPLE_BITS-1:0]  o_right_out;

    // filter state as the block should hold it
    logic signed [SAMPLE_BITS-1:0] hist_mem  [TAPS];
    logic signed [COEF_BITS-1:0]   left_coef [TAPS];
    logic signed [COEF_BITS-1:0]   right_coef[TAPS];
    int                            hist_ptr;

    t_stereo     pending_out[$];
    t_stereo     want;
    int          err_count;
    int          n_samples;
    int          n_tap_writes;
    int          n_dropped;
    int          n_checked;
    int          burst_left;
    int          cycle_count;
    t_stall_mode stall_mode;
    int          mode_cycles;
    int          hold_cnt;

    binaural_stereo_fir_convolver_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (r_rst_n),
        .i_valid       (r_valid),
        .o_stall       (o_stall),
        .i_opcode      (r_opcode),
        .i_tap_index   (r_tap_index),
        .i_sample_value(r_sample_value),
        .o_valid       (o_valid),
        .i_stall       (r_stall),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        foreach (hist_mem[k]) begin
            hist_mem[k]   = '0;
            left_coef[k]  = '0;
            right_coef[k] = '0;
        end
        hist_ptr     = 0;
        err_count    = 0;
        n_samples    = 0;
        n_tap_writes = 0;
        n_dropped    = 0;
        n_checked    = 0;
        burst_left   = 0;
        cycle_count  = 0;
        stall_mode   = STALL_NONE;
        mode_cycles  = 0;
        hold_cnt     = 0;
    end

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        err_count++;
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, exp_val, got_val);
    endtask

    // exact sum, round half up, saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input longint acc);
        longint q;
        longint top;
        top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        q = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
        if (q > top) begin
            q = top;
        end else if (q < -top - 1) begin
            q = -top - 1;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic model_transaction(input logic [1:0] op, input logic [IDX_BITS-1:0] idx,
                                     input logic signed [SAMPLE_BITS-1:0] val);
        longint  acc_l;
        longint  acc_r;
        int      slot;
        int      k;
        t_stereo res;
        case (op)
            OP_TAP_L: begin
                if (idx < TAPS) left_coef[idx] = val;
                n_tap_writes++;
            end
            OP_TAP_R: begin
                if (idx < TAPS) right_coef[idx] = val;
                n_tap_writes++;
            end
            OP_SAMPLE: begin
                hist_mem[hist_ptr] = val;
                acc_l = 0;
                acc_r = 0;
                for (k = 0; k < TAPS; k++) begin
                    slot = (hist_ptr + TAPS - k) % TAPS;
                    acc_l += longint'(hist_mem[slot]) * longint'(left_coef[k]);
                    acc_r += longint'(hist_mem[slot]) * longint'(right_coef[k]);
                end
                hist_ptr  = (hist_ptr + 1) % TAPS;
                res.left  = to_sample(acc_l);
                res.right = to_sample(acc_r);
                pending_out.push_back(res);
                n_samples++;
            end
            default: n_dropped++;
        endcase
    endtask

    // sender works in bursts; a gap drops valid for a while before the next transaction
    task automatic push_transaction(input logic [1:0] op, input logic [IDX_BITS-1:0] idx,
                                    input logic signed [SAMPLE_BITS-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                7:       gap = $urandom_range(1, 520);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                r_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        r_valid        <= 1'b1;
        r_opcode       <= op;
        r_tap_index    <= idx;
        r_sample_value <= val;
        do @(posedge i_clk); while (o_stall);
        model_transaction(op, idx, val);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_scaled();
        logic signed [SAMPLE_BITS-1:0] raw;
        raw = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return raw;
            4, 5:    return raw >>> $urandom_range(1, 6);
            default: return raw >>> $urandom_range(7, 12);
        endcase
    endfunction

    task automatic test_zero_taps();
        push_transaction(OP_SAMPLE, '0, 16'sh7fff);
        push_transaction(OP_SAMPLE, '1, 16'sh8000);
        push_transaction(OP_SAMPLE, '0, 16'sh0000);
    endtask

    task automatic test_tap_extremes();
        push_transaction(OP_TAP_L, 9'd0, 16'sh7fff);
        push_transaction(OP_TAP_R, 9'd0, 16'sh8000);
        push_transaction(OP_TAP_L, 9'd511, 16'sh8000);
        push_transaction(OP_TAP_R, 9'd511, 16'sh7fff);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh7fff);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh8000);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh5555);
    endtask

    // unit taps expose the half-up rounding of single products
    task automatic test_rounding();
        push_transaction(OP_TAP_L, 9'd0, 16'sh0001);
        push_transaction(OP_TAP_R, 9'd0, 16'shffff);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh4000);
        push_transaction(OP_SAMPLE, 9'd0, -16'sh4000);
        push_transaction(OP_SAMPLE, 9'd0, -16'sh4001);
    endtask

    task automatic test_saturation();
        push_transaction(OP_TAP_L, 9'd1, 16'sh8000);
        push_transaction(OP_TAP_L, 9'd2, 16'sh8000);
        push_transaction(OP_TAP_R, 9'd1, 16'sh7fff);
        push_transaction(OP_TAP_R, 9'd2, 16'sh7fff);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh8000);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh8000);
        push_transaction(OP_SAMPLE, 9'd0, 16'sh8000);
    endtask

    task automatic test_unused_opcode();
        push_transaction(OP_UNUSED, 9'd511, 16'sh8000);
        push_transaction(OP_UNUSED, 9'd0, 16'sh7fff);
    endtask

    task automatic test_random_stream(input int n_items);
        int counted;
        int pick;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_transaction(OP_SAMPLE, IDX_BITS'($urandom), rand_scaled());
            end else if (pick < 72) begin
                push_transaction(OP_TAP_L, IDX_BITS'($urandom_range(0, TAPS - 1)),
                                 rand_scaled());
            end else if (pick < 94) begin
                push_transaction(OP_TAP_R, IDX_BITS'($urandom_range(0, TAPS - 1)),
                                 rand_scaled());
            end else begin
                push_transaction(OP_UNUSED, IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
            counted++;
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (!r_rst_n) begin
            r_stall <= 1'b0;
        end else begin
            if (o_valid && !r_stall) begin
                if (pending_out.size() == 0) begin
                    report_mismatch("unexpected result, left", 0, int'(o_left_out));
                end else begin
                    want = pending_out.pop_front();
                    if (o_left_out !== want.left)
                        report_mismatch("left_out", int'(want.left), int'(o_left_out));
                    if (o_right_out !== want.right)
                        report_mismatch("right_out", int'(want.right), int'(o_right_out));
                    n_checked++;
                end
            end
            if (mode_cycles == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(0, 3));
                mode_cycles <= $urandom_range(500, 4000);
            end else begin
                mode_cycles <= mode_cycles - 1;
            end
            case (stall_mode)
                STALL_NONE:   r_stall <= 1'b0;
                STALL_RANDOM: r_stall <= ($urandom_range(0, 2) == 0);
                STALL_SHORT: begin
                    if (hold_cnt == 0) begin
                        r_stall  <= !r_stall;
                        hold_cnt <= $urandom_range(1, 40);
                    end else begin
                        hold_cnt <= hold_cnt - 1;
                    end
                end
                default: begin
                    // long holds make a finished result back up into the input side
                    if (hold_cnt == 0) begin
                        r_stall  <= !r_stall;
                        hold_cnt <= $urandom_range(1, 700);
                    end else begin
                        hold_cnt <= hold_cnt - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_out.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        r_rst_n <= 1'b1;
        test_zero_taps();
        test_tap_extremes();
        test_rounding();
        test_saturation();
        test_unused_opcode();
        test_random_stream(RANDOM_ITEMS);
        r_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d audio samples, %0d tap writes, %0d dropped opcodes sent",
                 n_samples, n_tap_writes, n_dropped);
        $display("summary: %0d stereo results compared in %0d cycles, %0d mismatches",
                 n_checked, cycle_count, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
design/bsfc_pkg.sv
design/bsfc_mac.sv
design/bsfc_ctrl.sv
design/binaural_stereo_fir_convolver_core.sv
sim/testbench.sv
